FILE: rtl/nfst_pkg.sv
`default_nettype none
package nfst_pkg;

  localparam int SLOT_COUNT = 2048;
  localparam int SLOT_W     = 11;
  localparam int ID_W       = 32;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int WORD_COUNT = SLOT_COUNT / WORD_W;
  localparam int WIDX_W     = $clog2(WORD_COUNT);
  localparam int CNT_W      = $clog2(WORD_COUNT + 1);

  localparam logic [ID_W-1:0] FREE_MARK = '1;

  localparam logic [1:0] KIND_ACQUIRE = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;
  localparam logic [1:0] ST_BADID = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   owner_id;
    logic [SLOT_W-1:0] slot_index;
    logic              deleted_ok;
    logic              owner_deleting;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] granted_slot;
    logic              hit;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_FINISH
  } state_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/nfst_ram.sv
`default_nettype none
module nfst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/next_fit_handle_slot_table.sv
`default_nettype none
// Next-fit slot table: 2048 slots, each holding a 32-bit owner id. Ownership lives
// in a used map of 64 words of 32 bits; owner ids sit in a separate 2048-entry RAM that
// is only trusted where the map marks the slot used. After reset the block clears all
// 64 words of the used map and takes no word until that pass is done.
// Release and lookup go from accept through the read state and the finish state to the
// result. An acquire scans the used map one word per cycle from the rotating pointer,
// reading 1 to 65 map words before a free slot is found or the table is known full.
// A bad id or unknown kind goes straight to the finish state. One word is worked on
// at a time; a finished result sits in the output register while the next word is taken.
module next_fit_handle_slot_table (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire nfst_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output nfst_pkg::out_t     out_data
);
  import nfst_pkg::*;

  state_t state_r, state_nxt;
  in_t    req_r;
  out_t   res_r, res_nxt;
  out_t   out_r;
  logic   out_valid_r;

  logic [SLOT_W-1:0] start_r, start_nxt;
  logic [WIDX_W-1:0] clr_cnt_r;
  logic [WIDX_W-1:0] chk_word_r;
  logic [CNT_W-1:0]  chk_cnt_r;
  logic              chk_first_r;

  logic              map_we;
  logic [WIDX_W-1:0] map_waddr, map_raddr;
  logic [WORD_W-1:0] map_wdata, map_rdata;
  logic              own_we;
  logic [SLOT_W-1:0] own_waddr, own_raddr;
  logic [ID_W-1:0]   own_wdata, own_rdata;

  logic              in_accept, out_load;
  logic [WORD_W-1:0] free_vec;
  logic [BIT_W-1:0]  hit_bit;
  logic              found, scan_last;
  logic [SLOT_W-1:0] gnt_slot;
  logic [WIDX_W-1:0] rq_word;
  logic [BIT_W-1:0]  rq_bit;
  logic              rq_used, rq_in_range;

  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(SLOT_COUNT);

  nfst_ram #(.WIDTH(WORD_W), .DEPTH(WORD_COUNT)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  nfst_ram #(.WIDTH(ID_W), .DEPTH(SLOT_COUNT)) u_owner (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .raddr (own_raddr),
    .rdata (own_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_load  = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // first map word only counts slots at or past the pointer
  assign free_vec  = ~map_rdata &
                     (chk_first_r ? ({WORD_W{1'b1}} << start_r[BIT_W-1:0]) : {WORD_W{1'b1}});
  assign found     = |free_vec;
  assign hit_bit   = lowest_set(free_vec);
  assign gnt_slot  = {chk_word_r, hit_bit};
  assign scan_last = (chk_cnt_r == CNT_W'(WORD_COUNT));

  assign rq_word     = req_r.slot_index[SLOT_W-1:BIT_W];
  assign rq_bit      = req_r.slot_index[BIT_W-1:0];
  assign rq_used     = map_rdata[rq_bit];
  assign rq_in_range = ({1'b0, req_r.slot_index} < SLOT_LIMIT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == WIDX_W'(WORD_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_data.kind == KIND_ACQUIRE && in_data.owner_id != FREE_MARK) begin
            state_nxt = S_SEARCH;
          end else if (in_data.kind == KIND_RELEASE ||
                       (in_data.kind == KIND_LOOKUP && in_data.owner_id != FREE_MARK)) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SEARCH: begin
        if (found || scan_last) state_nxt = S_FINISH;
      end
      S_READ:   state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    res_nxt   = res_r;
    start_nxt = start_r;
    map_we    = 1'b0;
    map_waddr = chk_word_r;
    map_wdata = map_rdata;
    map_raddr = chk_word_r + WIDX_W'(1);
    own_we    = 1'b0;
    own_waddr = gnt_slot;
    own_wdata = req_r.owner_id;
    own_raddr = in_data.slot_index;
    unique case (state_r)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_cnt_r;
        map_wdata = '0;
      end
      S_IDLE: begin
        map_raddr = (in_data.kind == KIND_ACQUIRE) ? start_r[SLOT_W-1:BIT_W]
                                                  : in_data.slot_index[SLOT_W-1:BIT_W];
        res_nxt.granted_slot = '0;
        res_nxt.hit          = 1'b0;
        res_nxt.status       = ((in_data.kind == KIND_ACQUIRE || in_data.kind == KIND_LOOKUP) &&
                                in_data.owner_id == FREE_MARK) ? ST_BADID : ST_MISS;
      end
      S_SEARCH: begin
        if (found) begin
          map_we               = 1'b1;
          map_wdata            = map_rdata | (WORD_W'(1) << hit_bit);
          own_we               = 1'b1;
          res_nxt.status       = ST_OK;
          res_nxt.granted_slot = gnt_slot;
          start_nxt = ({1'b0, gnt_slot} == SLOT_LIMIT - 1'b1) ? '0 : gnt_slot + SLOT_W'(1);
        end else if (scan_last) begin
          res_nxt.status = ST_FULL;
        end
      end
      S_READ: begin
        map_waddr = rq_word;
        map_wdata = map_rdata & ~(WORD_W'(1) << rq_bit);
        if (req_r.kind == KIND_RELEASE) begin
          if (rq_in_range && rq_used) begin
            map_we         = 1'b1;
            res_nxt.status = ST_OK;
          end
        end else if (rq_in_range && rq_used && own_rdata == req_r.owner_id &&
                     (req_r.deleted_ok || !req_r.owner_deleting)) begin
          res_nxt.status = ST_OK;
          res_nxt.hit    = 1'b1;
        end
      end
      S_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + WIDX_W'(1);
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_accept) begin
      req_r       <= in_data;
      chk_word_r  <= start_r[SLOT_W-1:BIT_W];
      chk_cnt_r   <= '0;
      chk_first_r <= 1'b1;
    end else if (state_r == S_SEARCH) begin
      chk_word_r  <= chk_word_r + WIDX_W'(1);
      chk_cnt_r   <= chk_cnt_r + CNT_W'(1);
      chk_first_r <= 1'b0;
    end
    if (out_load) out_r <= res_r;
  end

endmodule
`default_nettype wire
